// File: rtl/core/pixel_effect_unit_assert.svh
// Assertion macros used by the checker in pxe_checker.sv
`ifndef PIXEL_EFFECT_UNIT_ASSERT_SVH
`define PIXEL_EFFECT_UNIT_ASSERT_SVH

// Clocked check, disabled while reset is asserted
`define PXE_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Clocked check that stays live through reset
`define PXE_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// File: rtl/core/pxe_pkg.sv
package pxe_pkg;

    localparam int ChanW    = 8;
    localparam int PixelW   = 32;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int OffsetW  = 9;

    typedef enum logic [2:0] {
        MODE_PASS      = 3'd0,
        MODE_INVERT    = 3'd1,
        MODE_GREY      = 3'd2,
        MODE_GREEN     = 3'd3,
        MODE_THRESHOLD = 3'd4,
        MODE_OFFSET    = 3'd5,
        MODE_BLEND     = 3'd6,
        MODE_KEY       = 3'd7
    } effect_mode_t;

    typedef enum logic [2:0] {
        CFG_EFFECT_MODE  = 3'd0,
        CFG_THRESHOLD    = 3'd1,
        CFG_RED_OFFSET   = 3'd2,
        CFG_GREEN_OFFSET = 3'd3,
        CFG_BLUE_OFFSET  = 3'd4,
        CFG_KEY_COLOUR   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        effect_mode_t               effect_mode;
        logic [PixelW-1:0]          threshold_rgba;
        logic signed [OffsetW-1:0]  red_offset;
        logic signed [OffsetW-1:0]  green_offset;
        logic signed [OffsetW-1:0]  blue_offset;
        logic [PixelW-1:0]          key_colour;
    } pxe_cfg_t;

    // floor(p / 255), exact for p <= 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // floor(s / 3) for s <= 765, reciprocal 683 / 2048
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [19:0] t;
        t = 20'(s) * 20'd683;
        return t[18:11];
    endfunction

    function automatic logic [7:0] sat_add(input logic [7:0] c,
                                           input logic signed [8:0] off);
        logic signed [9:0] s;
        s = signed'({2'b00, c}) + signed'({off[8], off});
        if (s[9]) begin
            return 8'd0;
        end else if (s[8]) begin
            return 8'd255;
        end else begin
            return s[7:0];
        end
    endfunction

endpackage

// File: rtl/core/pxe_cfg_regs.sv
module pxe_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pxe_pkg::CfgIdxW-1:0]   cfg_addr,
    input  logic [pxe_pkg::CfgDataW-1:0]  cfg_wdata,
    output pxe_pkg::pxe_cfg_t             cfg
);

    pxe_pkg::pxe_cfg_t cfg_reg;
    pxe_pkg::pxe_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (pxe_pkg::cfg_idx_t'(cfg_addr))
                pxe_pkg::CFG_EFFECT_MODE: begin
                    cfg_next.effect_mode = pxe_pkg::effect_mode_t'(cfg_wdata[2:0]);
                end
                pxe_pkg::CFG_THRESHOLD:    cfg_next.threshold_rgba = cfg_wdata;
                pxe_pkg::CFG_RED_OFFSET:   cfg_next.red_offset     = cfg_wdata[8:0];
                pxe_pkg::CFG_GREEN_OFFSET: cfg_next.green_offset   = cfg_wdata[8:0];
                pxe_pkg::CFG_BLUE_OFFSET:  cfg_next.blue_offset    = cfg_wdata[8:0];
                pxe_pkg::CFG_KEY_COLOUR:   cfg_next.key_colour     = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/pxe_datapath.sv
module pxe_datapath (
    input  pxe_pkg::pxe_cfg_t             cfg,
    input  logic [pxe_pkg::PixelW-1:0]    canvas_pixel,
    input  logic [pxe_pkg::PixelW-1:0]    image_pixel,
    output logic [pxe_pkg::PixelW-1:0]    result_pixel
);

    logic [7:0]  r, g, b, a;
    logic [7:0]  ir, ig, ib, sa, ia;
    logic [7:0]  tr, tg, tb, ta;
    logic [9:0]  sum;
    logic [7:0]  avg;
    logic [7:0]  nr, ng, nb;

    assign r  = canvas_pixel[31:24];
    assign g  = canvas_pixel[23:16];
    assign b  = canvas_pixel[15:8];
    assign a  = canvas_pixel[7:0];
    assign ir = image_pixel[31:24];
    assign ig = image_pixel[23:16];
    assign ib = image_pixel[15:8];
    assign sa = image_pixel[7:0];
    assign ia = 8'd255 - sa;
    assign tr = cfg.threshold_rgba[31:24];
    assign tg = cfg.threshold_rgba[23:16];
    assign tb = cfg.threshold_rgba[15:8];
    assign ta = cfg.threshold_rgba[7:0];

    assign sum = 10'(r) + 10'(g) + 10'(b);
    assign avg = pxe_pkg::div3(sum);

    // each pair of terms sums to at most 255
    assign nr = pxe_pkg::div255(16'(ir) * 16'(sa)) + pxe_pkg::div255(16'(r) * 16'(ia));
    assign ng = pxe_pkg::div255(16'(ig) * 16'(sa)) + pxe_pkg::div255(16'(g) * 16'(ia));
    assign nb = pxe_pkg::div255(16'(ib) * 16'(sa)) + pxe_pkg::div255(16'(b) * 16'(ia));

    always_comb begin
        unique case (cfg.effect_mode)
            pxe_pkg::MODE_PASS:   result_pixel = canvas_pixel;
            pxe_pkg::MODE_INVERT: result_pixel = {~r, ~g, ~b, a};
            pxe_pkg::MODE_GREY:   result_pixel = {avg, avg, avg, a};
            pxe_pkg::MODE_GREEN:  result_pixel = {8'd0, avg, 8'd0, a};
            pxe_pkg::MODE_THRESHOLD: begin
                result_pixel = {(r >= tr) ? r : 8'd0, (g >= tg) ? g : 8'd0,
                                (b >= tb) ? b : 8'd0, (a >= ta) ? a : 8'd0};
            end
            pxe_pkg::MODE_OFFSET: begin
                result_pixel = {pxe_pkg::sat_add(r, cfg.red_offset),
                                pxe_pkg::sat_add(g, cfg.green_offset),
                                pxe_pkg::sat_add(b, cfg.blue_offset), a};
            end
            pxe_pkg::MODE_BLEND:  result_pixel = {nr, ng, nb, a};
            pxe_pkg::MODE_KEY: begin
                result_pixel = (image_pixel == cfg.key_colour) ? canvas_pixel : image_pixel;
            end
            default:              result_pixel = canvas_pixel;
        endcase
    end

endmodule

// File: rtl/core/pixel_effect_unit.sv
// Pixel effect unit: one RGBA8888 point operation per pixel.
// Input channel s_*: one transaction carries a canvas pixel and an image
// pixel. Output channel m_*: one transaction carries the new canvas pixel.
// Pixels are red in bits 31..24 down to alpha in bits 7..0.
// The effect is selected by the effect_mode register, written through the
// cfg_* port (index 0 mode, 1 thresholds, 2..4 RGB offsets, 5 key colour).
// Write configuration only while no transaction is in flight.
// The input register takes the pixel at the input transaction edge, and the
// result register takes the datapath result from it when the output register
// is empty or being read, which sets m_tvalid; the result goes out on m_tready.
// Throughput: one pixel per cycle while m_tready stays high, set by the single
// pass datapath between the two registers.
// Reset (aresetn low, synchronous) empties both stages and clears all
// configuration registers to zero (pass-through mode).
// When the receiver stalls, the result holds in the output register; the
// input register still takes one more pixel if it is empty, after which
// s_tready drops until m_tready returns.
module pixel_effect_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // image_pixel 63..32, canvas_pixel 31..0
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pxe_pkg::PixelW-1:0]    m_tdata,   // result_pixel
    input  logic                          cfg_wr_en,
    input  logic [pxe_pkg::CfgIdxW-1:0]   cfg_addr,
    input  logic [pxe_pkg::CfgDataW-1:0]  cfg_wdata
);

    pxe_pkg::pxe_cfg_t              cfg;
    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic [pxe_pkg::PixelW-1:0]     canvas_reg;
    logic [pxe_pkg::PixelW-1:0]     image_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [pxe_pkg::PixelW-1:0]     result_reg;
    logic [pxe_pkg::PixelW-1:0]     result_next;
    logic                           advance;
    logic                           s_accept;

    pxe_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pxe_datapath u_datapath (
        .cfg          (cfg),
        .canvas_pixel (canvas_reg),
        .image_pixel  (image_reg),
        .result_pixel (result_next)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            canvas_reg <= s_tdata[31:0];
            image_reg  <= s_tdata[63:32];
        end
        if (advance && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

// File: rtl/core/pxe_checker.sv
`include "pixel_effect_unit_assert.svh"

module pxe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pxe_pkg::PixelW-1:0]    m_tdata
);

    `PXE_ASSERT_RST(a_reset_empties_output, aclk, !aresetn |=> !m_tvalid)
    `PXE_ASSERT(a_stall_holds_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `PXE_ASSERT(a_stall_holds_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata))
    `PXE_ASSERT(a_ready_when_drained, aclk, aresetn, m_tready |-> s_tready)
    `PXE_ASSERT(a_from_input, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))

endmodule

bind pixel_effect_unit pxe_checker u_pxe_checker (.*);

// File: verif/pixel_effect_checker.sv
module pixel_effect_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // image_pixel 63..32, canvas_pixel 31..0
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [pxe_pkg::PixelW-1:0]    m_tdata,   // result_pixel
    input  logic                          cfg_wr_en,
    input  logic [pxe_pkg::CfgIdxW-1:0]   cfg_addr,
    input  logic [pxe_pkg::CfgDataW-1:0]  cfg_wdata,
    output int                            errors,
    output int                            pending,
    output int                            checked
);
    import pxe_pkg::*;

    effect_mode_t              mode_q;
    logic [PixelW-1:0]         thresholds_q;
    logic signed [OffsetW-1:0] red_off_q;
    logic signed [OffsetW-1:0] green_off_q;
    logic signed [OffsetW-1:0] blue_off_q;
    logic [PixelW-1:0]         key_q;

    logic [PixelW-1:0] pixels_due[$];

    function automatic logic [7:0] keep_at_least(input logic [7:0] c, input logic [7:0] t);
        return (c >= t) ? c : 8'd0;
    endfunction

    function automatic logic [7:0] clamp_offset(input logic [7:0] c,
                                                input logic signed [8:0] off);
        int s;
        s = int'(c) + int'(off);
        if (s < 0) begin
            return 8'd0;
        end else if (s > 255) begin
            return 8'd255;
        end
        return 8'(s);
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] fg, input logic [7:0] bg,
                                       input logic [7:0] alpha);
        int unsigned sum;
        sum = (int'(fg) * int'(alpha)) / 255 + (int'(bg) * (255 - int'(alpha))) / 255;
        return 8'(sum);
    endfunction

    function automatic logic [PixelW-1:0] effect_of(input logic [PixelW-1:0] cp,
                                                    input logic [PixelW-1:0] ip);
        logic [7:0] r, g, b, a, avg;
        int unsigned total;
        r = cp[31:24];
        g = cp[23:16];
        b = cp[15:8];
        a = cp[7:0];
        total = int'(r) + int'(g) + int'(b);
        avg = 8'(total / 3);
        case (mode_q)
            MODE_INVERT: return {8'd255 - r, 8'd255 - g, 8'd255 - b, a};
            MODE_GREY: return {avg, avg, avg, a};
            MODE_GREEN: return {8'd0, avg, 8'd0, a};
            MODE_THRESHOLD: return {keep_at_least(r, thresholds_q[31:24]),
                                    keep_at_least(g, thresholds_q[23:16]),
                                    keep_at_least(b, thresholds_q[15:8]),
                                    keep_at_least(a, thresholds_q[7:0])};
            MODE_OFFSET: return {clamp_offset(r, red_off_q), clamp_offset(g, green_off_q),
                                 clamp_offset(b, blue_off_q), a};
            MODE_BLEND: return {mix(ip[31:24], r, ip[7:0]), mix(ip[23:16], g, ip[7:0]),
                                mix(ip[15:8], b, ip[7:0]), a};
            MODE_KEY: return (ip == key_q) ? cp : ip;
            default: return cp;
        endcase
    endfunction

    always @(posedge aclk) begin
        logic [PixelW-1:0] want;
        if (!aresetn) begin
            mode_q       <= MODE_PASS;
            thresholds_q <= '0;
            red_off_q    <= '0;
            green_off_q  <= '0;
            blue_off_q   <= '0;
            key_q        <= '0;
            pixels_due.delete();
            errors       <= 0;
            pending      <= 0;
            checked      <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_EFFECT_MODE: mode_q <= effect_mode_t'(cfg_wdata[2:0]);
                    CFG_THRESHOLD: thresholds_q <= cfg_wdata;
                    CFG_RED_OFFSET: red_off_q <= cfg_wdata[OffsetW-1:0];
                    CFG_GREEN_OFFSET: green_off_q <= cfg_wdata[OffsetW-1:0];
                    CFG_BLUE_OFFSET: blue_off_q <= cfg_wdata[OffsetW-1:0];
                    CFG_KEY_COLOUR: key_q <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pixels_due.push_back(effect_of(s_tdata[31:0], s_tdata[63:32]));
            end
            if (m_tvalid && m_tready) begin
                if (pixels_due.size() == 0) begin
                    if (errors < 10) begin
                        $display("%0t: unexpected result transaction %08h", $time, m_tdata);
                    end
                    errors <= errors + 1;
                end else begin
                    want = pixels_due.pop_front();
                    checked <= checked + 1;
                    if (m_tdata !== want) begin
                        if (errors < 10) begin
                            $display("%0t: result_pixel mismatch: expected %08h, got %08h",
                                     $time, want, m_tdata);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            pending <= pixels_due.size();
        end
    end

endmodule

// File: verif/tb_top.sv
module tb_top;
    import pxe_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_7 = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [PixelW-1:0]     m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]    cfg_addr = '0;
    logic [CfgDataW-1:0]   cfg_wdata = '0;

    int errors, pending, checked;
    int pixels_sent = 0;
    int settings_used = 0;
    int burst_left = 0;
    int hold_left = 0;

    logic [PixelW-1:0] key_now = '0;
    logic [PixelW-1:0] thr_now = '0;

    pixel_effect_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    pixel_effect_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending), .checked(checked)
    );

    always #4 aclk = ~aclk;

    // receiver back-pressure: runs of ready, short stalls, occasional long stalls
    always @(negedge aclk) begin
        int pick;
        if (hold_left > 0) begin
            hold_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                m_tready = 1'b1;
                hold_left = $urandom_range(0, 24);
            end else if (pick < 88) begin
                m_tready = 1'b0;
                hold_left = $urandom_range(0, 3);
            end else begin
                m_tready = 1'b0;
                hold_left = $urandom_range(5, 30);
            end
        end
    end

    task automatic push_pixel(input logic [PixelW-1:0] canvas, input logic [PixelW-1:0] image);
        s_tdata = {image, canvas};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
    endtask

    task automatic drain;
        s_tvalid = 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_KEY_COLOUR) key_now = value;
        if (idx == CFG_THRESHOLD) thr_now = value;
    endtask

    task automatic set_mode(input effect_mode_t mode);
        write_reg(CFG_EFFECT_MODE, {29'($urandom), 3'(mode)});
        settings_used++;
    endtask

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [PixelW-1:0] random_pixel();
        if ($urandom_range(0, 2) == 0) begin
            return {random_channel(), random_channel(), random_channel(), random_channel()};
        end
        return $urandom;
    endfunction

    function automatic logic [CfgDataW-1:0] random_offset();
        logic [8:0] off;
        case ($urandom_range(0, 7))
            0: off = 9'h100;
            1: off = 9'h0ff;
            2: off = 9'h101;
            3: off = 9'h000;
            default: off = 9'($urandom);
        endcase
        return {23'($urandom), off};
    endfunction

    initial begin
        effect_mode_t mode;
        logic [PixelW-1:0] canvas, image;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // pass-through straight out of reset
        push_pixel(32'h0000_0000, 32'hffff_ffff);
        push_pixel(32'hffff_ffff, 32'h0000_0000);
        drain();
        set_mode(MODE_INVERT);
        push_pixel(32'h0000_0000, 32'h0000_0000);
        push_pixel(32'hffff_ffff, 32'hffff_ffff);
        push_pixel(32'h1234_5678, 32'h9abc_def0);
        drain();
        set_mode(MODE_GREY);
        push_pixel(32'hffff_ff00, 32'h0);
        push_pixel(32'h0101_0180, 32'h0);
        push_pixel(32'h0200_0000, 32'h0);
        drain();
        set_mode(MODE_GREEN);
        push_pixel(32'hffff_ffff, 32'h0);
        push_pixel(32'h0201_00aa, 32'h0);
        drain();
        set_mode(MODE_THRESHOLD);
        write_reg(CFG_THRESHOLD, 32'h8080_8080);
        push_pixel(32'h7f80_ff7f, 32'h0);
        push_pixel(32'h807f_7f80, 32'h0);
        drain();
        write_reg(CFG_THRESHOLD, 32'hffff_ffff);
        push_pixel(32'hfeff_feff, 32'h0);
        drain();
        set_mode(MODE_OFFSET);
        write_reg(CFG_RED_OFFSET, 32'h0000_0100);
        write_reg(CFG_GREEN_OFFSET, 32'h0000_00ff);
        write_reg(CFG_BLUE_OFFSET, 32'h0000_0101);
        push_pixel(32'hff00_ff55, 32'h0);
        push_pixel(32'h00ff_0055, 32'h0);
        drain();
        // upper bits of a wide write are dropped: red offset becomes +1
        write_reg(CFG_RED_OFFSET, 32'hffff_fe01);
        write_reg(CFG_SPARE_6, 32'hffff_ffff);
        write_reg(CFG_SPARE_7, 32'hffff_ffff);
        push_pixel(32'hfe7f_80c3, 32'h0);
        drain();
        set_mode(MODE_BLEND);
        push_pixel(32'hffff_ff11, 32'h0000_0000);
        push_pixel(32'h0000_0022, 32'hffff_ffff);
        push_pixel(32'h00ff_80cc, 32'hff80_007f);
        drain();
        set_mode(MODE_KEY);
        push_pixel(32'h1122_3344, 32'h0000_0000);
        drain();
        write_reg(CFG_KEY_COLOUR, 32'hdead_beef);
        push_pixel(32'h1122_3344, 32'hdead_beef);
        push_pixel(32'h1122_3344, 32'hdead_beee);
        push_pixel(32'hffff_ffff, 32'h5ead_beef);
        drain();
        write_reg(CFG_EFFECT_MODE, 32'hffff_fff8);
        push_pixel(32'hcafe_f00d, 32'h0bad_cafe);

        for (int phase = 0; phase < 21; phase++) begin
            drain();
            mode = (phase < 8) ? effect_mode_t'(phase) : effect_mode_t'($urandom_range(0, 7));
            set_mode(mode);
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_THRESHOLD, 32'h0);
                    1: write_reg(CFG_THRESHOLD, 32'hffff_ffff);
                    default: write_reg(CFG_THRESHOLD, $urandom);
                endcase
            end
            if ($urandom_range(0, 1)) write_reg(CFG_RED_OFFSET, random_offset());
            if ($urandom_range(0, 1)) write_reg(CFG_GREEN_OFFSET, random_offset());
            if ($urandom_range(0, 1)) write_reg(CFG_BLUE_OFFSET, random_offset());
            if ($urandom_range(0, 1)) write_reg(CFG_KEY_COLOUR, random_pixel());
            if ($urandom_range(0, 4) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
            end
            for (int n = 0; n < 25; n++) begin
                canvas = random_pixel();
                image = random_pixel();
                if (mode == MODE_KEY && $urandom_range(0, 9) < 4) image = key_now;
                if (mode == MODE_THRESHOLD && $urandom_range(0, 3) == 0) canvas = thr_now;
                if (phase == 10 && n == 12) drain();
                push_pixel(canvas, image);
            end
        end

        drain();
        repeat (12) @(negedge aclk);
        $display("summary: %0d pixels over %0d mode settings, %0d results checked, %0d errors",
                 pixels_sent, settings_used, checked, errors);
        $display("summary: all eight effects, register extremes and spare-index writes covered");
        if (errors == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #3200000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
